// ----- hdl/bloom_filter_insert_query_macros.svh -----
// Assertion macros for the bloom filter RTL (used by bfiq_back)
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BFIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define BFIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bfiq_pkg.sv -----
// Shared types and constants for the bloom filter engine
`default_nettype none
package bfiq_pkg;
  localparam int unsigned MAX_FILTER_BYTES = 4096;
  localparam int unsigned ADDR_W = $clog2(MAX_FILTER_BYTES);
  localparam int unsigned BITS_W = $clog2(MAX_FILTER_BYTES * 8) + 1;
  localparam int unsigned QDEPTH = 2;

  localparam logic [31:0] HASH_MUL  = 32'h0100_0193;
  localparam logic [31:0] PROBE_MUL = 32'hfba4_c795;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] REG_TWEAK = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_BYTES = 2'd2;
  localparam logic [1:0] REG_MALL  = 2'd3;

  typedef struct packed {
    logic [1:0]   opcode;
    logic [11:0]  byte_index;
    logic [7:0]   byte_value;
    logic [255:0] hash;
  } item_t;

  typedef struct packed {
    logic [31:0] hash_tweak;
    logic [7:0]  hash_count;
    logic [12:0] filter_bytes;
    logic        match_all;
  } cfg_t;
endpackage
`default_nettype wire

// ----- hdl/bloom_filter_insert_query.sv -----
// Top level of the bloom filter insert/query engine
//
//  channel  | direction | tdata (low bit up)                                   | tuser
//  in_      | slave     | byte_index, byte_value, hash_word0..3, pad to 280    | opcode
//  out_     | master    | matched, skipped, pad to 8                           | -
//  cfg_     | write     | cfg_index selects hash_tweak/hash_count/filter_bytes/match_all
//
// Write and clear finish in the back end's pop cycle; so do adds and queries needing no probe.
// Other adds and queries run the 32 hash multiplies and then, per probe, a bit-serial remainder
// and a store read (written back with the bit set for adds); a query stops at its first clear bit.
// Reset is synchronous on rst_n; the filter store is not cleared and needs no sweep.
// A two-entry queue takes transactions until full while the back end works or out_tready is low.
`default_nettype none
module bloom_filter_insert_query (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [279:0] in_tdata,   // byte_index, byte_value, hash_word0..3
  input  wire logic [1:0]   in_tuser,   // opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,  // matched, skipped
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  bfiq_pkg::cfg_t  cfg_r;
  bfiq_pkg::item_t in_item, q_item;
  logic q_valid, q_pop, matched, skipped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bfiq_pkg::REG_TWEAK: cfg_r.hash_tweak   <= cfg_wdata;
        bfiq_pkg::REG_COUNT: cfg_r.hash_count   <= cfg_wdata[7:0];
        bfiq_pkg::REG_BYTES: cfg_r.filter_bytes <= cfg_wdata[12:0];
        bfiq_pkg::REG_MALL:  cfg_r.match_all    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_item.opcode     = in_tuser;
  assign in_item.byte_index = in_tdata[11:0];
  assign in_item.byte_value = in_tdata[19:12];
  assign in_item.hash       = in_tdata[275:20];

  bfiq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  bfiq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_matched (matched),
    .out_skipped (skipped)
  );

  assign out_tdata = {6'd0, skipped, matched};
endmodule
`default_nettype wire

// ----- hdl/bfiq_front.sv -----
// Input side: accepts transactions into a two-entry queue
`default_nettype none
module bfiq_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bfiq_pkg::item_t in_item,
  output logic                q_valid,
  output bfiq_pkg::item_t     q_item,
  input  wire logic           q_pop
);
  localparam int unsigned PW = $clog2(bfiq_pkg::QDEPTH);

  bfiq_pkg::item_t mem_r [bfiq_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push;

  assign in_ready = (cnt_r != (PW+1)'(bfiq_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (q_pop) rp_r <= rp_r + PW'(1);
      if (push && !q_pop) cnt_r <= cnt_r + (PW+1)'(1);
      else if (!push && q_pop) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bfiq_back.sv -----
// Execution side: hash, probe modulo, filter store and result register
`default_nettype none
`include "bloom_filter_insert_query_macros.svh"
module bfiq_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bfiq_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire bfiq_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_matched,
  output logic                 out_skipped
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam int unsigned AW = bfiq_pkg::ADDR_W;
  localparam int unsigned BW = bfiq_pkg::BITS_W;

  logic [7:0] store [bfiq_pkg::MAX_FILTER_BYTES];

  logic [2:0]   state_r;
  logic [31:0]  h_r, pm_r, dvd_r;
  logic [255:0] sh_r;
  logic [4:0]   k_r, cnt_r;
  logic [7:0]   i_r, rd_r;
  logic [BW-2:0] rem_r;
  logic [1:0]   op_r;
  logic         loaded_r, res_m_r;
  logic         out_valid_r, out_m_r, out_s_r;

  logic [12:0]  nbytes;
  logic [BW-1:0] bits;
  logic         empty, slot_free;
  logic [31:0]  h_mul, h_nxt, pm_nxt;
  logic [BW-1:0] rem_sh, rem_nxt;
  logic         bit_set, last_probe;
  logic         st_we;
  logic [AW-1:0] st_wa;
  logic [7:0]   st_wd;
  logic         probe_ok, fast_done, post, rem_ok, in_div;

  assign nbytes = (cfg.filter_bytes > 13'(bfiq_pkg::MAX_FILTER_BYTES))
                  ? 13'(bfiq_pkg::MAX_FILTER_BYTES) : cfg.filter_bytes;
  assign bits   = BW'({nbytes, 3'b000});
  assign empty  = (nbytes == '0);
  assign slot_free = !out_valid_r || out_ready;
  assign q_pop  = (state_r == S_IDLE) && q_valid && slot_free;

  // Adds and queries that need no probe finish in the pop cycle
  assign probe_ok  = loaded_r && !empty && (cfg.hash_count != '0);
  assign fast_done = !((q_item.opcode == bfiq_pkg::OP_ADD && probe_ok) ||
                       (q_item.opcode == bfiq_pkg::OP_QUERY && !cfg.match_all && probe_ok));
  assign post      = (q_pop && fast_done) || (state_r == S_FIN && slot_free);

  assign h_mul  = h_r * bfiq_pkg::HASH_MUL;
  assign h_nxt  = h_mul ^ {24'd0, sh_r[7:0]};
  assign pm_nxt = pm_r + bfiq_pkg::PROBE_MUL;

  // One remainder bit per cycle: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign rem_nxt = (rem_sh >= bits) ? rem_sh - bits : rem_sh;

  assign bit_set    = rd_r[rem_r[2:0]];
  assign last_probe = (i_r == cfg.hash_count - 8'd1);
  assign rem_ok     = ({1'b0, rem_r} < bits);
  assign in_div     = (state_r == S_MOD) || (state_r == S_RD);

  always_comb begin
    st_we = 1'b0;
    st_wa = rem_r[AW+2:3];
    st_wd = rd_r | (8'd1 << rem_r[2:0]);
    if (q_pop && q_item.opcode == bfiq_pkg::OP_WRITE) begin
      st_we = 1'b1;
      st_wa = q_item.byte_index[AW-1:0];
      st_wd = q_item.byte_value;
    end else if (state_r == S_CHK && op_r == bfiq_pkg::OP_ADD) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    rd_r <= store[rem_r[AW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            op_r <= q_item.opcode;
            h_r  <= cfg.hash_tweak;
            sh_r <= q_item.hash;
            k_r  <= '0;
            case (q_item.opcode)
              bfiq_pkg::OP_WRITE: begin
                loaded_r    <= 1'b1;
                out_m_r     <= 1'b0;
                out_s_r     <= 1'b0;
              end
              bfiq_pkg::OP_ADD: begin
                if (!loaded_r || empty || cfg.hash_count == '0) begin
                  out_m_r     <= 1'b0;
                  out_s_r     <= !loaded_r || empty;
                end else begin
                  state_r <= S_HASH;
                end
              end
              bfiq_pkg::OP_QUERY: begin
                if (cfg.match_all || !loaded_r || empty || cfg.hash_count == '0) begin
                  out_m_r     <= 1'b1;
                  out_s_r     <= 1'b0;
                end else begin
                  state_r <= S_HASH;
                end
              end
              default: begin
                loaded_r    <= 1'b0;
                out_m_r     <= 1'b0;
                out_s_r     <= 1'b0;
              end
            endcase
          end
        end
        S_HASH: begin
          h_r  <= h_nxt;
          sh_r <= sh_r >> 8;
          k_r  <= k_r + 5'd1;
          if (k_r == 5'd31) begin
            dvd_r   <= h_nxt;
            pm_r    <= '0;
            i_r     <= '0;
            rem_r   <= '0;
            cnt_r   <= '0;
            res_m_r <= 1'b1;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          rem_r <= rem_nxt[BW-2:0];
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (op_r == bfiq_pkg::OP_QUERY && !bit_set) begin
            res_m_r <= 1'b0;
            state_r <= S_FIN;
          end else if (last_probe) begin
            res_m_r <= (op_r == bfiq_pkg::OP_QUERY);
            state_r <= S_FIN;
          end else begin
            // advance to the next probe
            i_r     <= i_r + 8'd1;
            pm_r    <= pm_nxt;
            dvd_r   <= h_r ^ pm_nxt;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MOD;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_m_r     <= res_m_r;
            out_s_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_m_r;
  assign out_skipped = out_s_r;

  `BFIQ_ASSERT_NOW(a_pop_idle, q_pop, state_r == S_IDLE, "pop outside idle")
  `BFIQ_ASSERT_NOW(a_rem_range, in_div, rem_ok, "remainder out of range")
  `BFIQ_ASSERT_NEXT(a_fin_out, state_r == S_FIN && slot_free, out_valid_r && state_r == S_IDLE, "result not posted")
endmodule
`default_nettype wire
